// ===== hdl/tidt_pkg.sv =====
// tidt_pkg: shared types and constants of the typed integer to decimal text unit.
// No dependencies; used by tidt_bcd.sv and typed_integer_to_decimal_text_unit.sv.
package tidt_pkg;

  localparam logic [2:0] TC_BOOL = 3'd0;
  localparam logic [2:0] TC_RAW  = 3'd1;
  localparam logic [2:0] TC_U16  = 3'd2;
  localparam logic [2:0] TC_S16  = 3'd3;
  localparam logic [2:0] TC_U32  = 3'd4;
  localparam logic [2:0] TC_S32  = 3'd5;
  localparam logic [2:0] TC_U64  = 3'd6;
  localparam logic [2:0] TC_S64  = 3'd7;

  localparam logic [7:0] CH_ONE   = 8'h31;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_TERM  = 8'h00;

  typedef enum logic [2:0] {
    S_IDLE,
    S_ONE,
    S_CONV,
    S_SIGN,
    S_SKIP,
    S_DIGIT,
    S_TERM
  } state_t;

  // controls of the shared BCD unit
  typedef struct packed {
    logic load;
    logic step;
    logic shift;
  } bcd_ctl_t;

endpackage

// ===== hdl/tidt_if.sv =====
// tidt_if: request and result channels of the typed integer to decimal text unit.
// Depends on nothing; valid/ready handshake, a request moves on valid and ready high.
interface tidt_item_if;
  logic        valid;
  logic        ready;
  logic [2:0]  type_code;
  logic [63:0] value;

  modport source(output valid, type_code, value, input ready);
  modport sink(input valid, type_code, value, output ready);
endinterface

interface tidt_text_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       last;

  modport source(output valid, out_byte, last, input ready);
  modport sink(input valid, out_byte, last, output ready);
endinterface

// ===== hdl/tidt_bcd.sv =====
// tidt_bcd: shift-and-add-3 binary to BCD unit, four bits per step, digit shift-out.
// Depends on tidt_pkg (bcd_ctl_t).
module tidt_bcd #(
  parameter int VALUE_WIDTH = 64
) (
  input  logic                              clk,
  input  tidt_pkg::bcd_ctl_t                ctl,
  input  logic [4*((VALUE_WIDTH+3)/4)-1:0]  load_bits,
  output logic [3:0]                        top_digit
);

  localparam int SW   = 4 * ((VALUE_WIDTH + 3) / 4);
  localparam int NDIG = (VALUE_WIDTH * 1233) / 4096 + 1;
  localparam int BW   = 4 * NDIG;

  logic [SW-1:0] shreg;
  logic [BW-1:0] bcd;
  logic [SW-1:0] sh_step;
  logic [BW-1:0] bcd_step;

  always_comb begin
    bcd_step = bcd;
    sh_step  = shreg;
    for (int b = 0; b < 4; b++) begin
      for (int d = 0; d < NDIG; d++) begin
        if (bcd_step[4*d +: 4] >= 4'd5) begin
          bcd_step[4*d +: 4] = bcd_step[4*d +: 4] + 4'd3;
        end
      end
      bcd_step = {bcd_step[BW-2:0], sh_step[SW-1]};
      sh_step  = {sh_step[SW-2:0], 1'b0};
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.load) begin
      shreg <= load_bits;
      bcd   <= '0;
    end else if (ctl.step) begin
      shreg <= sh_step;
      bcd   <= bcd_step;
    end else if (ctl.shift) begin
      bcd <= {bcd[BW-5:0], 4'b0000};
    end
  end

  assign top_digit = bcd[BW-1 -: 4];

endmodule

// ===== hdl/typed_integer_to_decimal_text_unit.sv =====
// typed_integer_to_decimal_text_unit: serializes one typed value as a run of text bytes.
// Depends on tidt_pkg, tidt_if (tidt_item_if, tidt_text_if) and tidt_bcd.
// Bool and raw byte: one byte, ready again once that byte has gone to the output register.
// Numbers: load on acceptance, conversion of the w-bit magnitude in the shared BCD unit (w = 16,
// 32 or VALUE_WIDTH), a sign byte for signed types, leading-zero skip over the NDIG digits plus
// digit output (NDIG = 20 at VALUE_WIDTH 64), then a terminator byte.
// One request at a time; output stalls extend the emit cycles. Sync reset returns to idle.
module typed_integer_to_decimal_text_unit #(
  parameter int VALUE_WIDTH = 64
) (
  input logic         clk,
  input logic         rst,
  tidt_item_if.sink   item,
  tidt_text_if.source text
);

  localparam int SW   = 4 * ((VALUE_WIDTH + 3) / 4);
  localparam int NDIG = (VALUE_WIDTH * 1233) / 4096 + 1;
  localparam int W32  = (VALUE_WIDTH < 32) ? VALUE_WIDTH : 32;
  localparam int S16  = 4;
  localparam int S32  = (W32 + 3) / 4;
  localparam int S64  = (VALUE_WIDTH + 3) / 4;
  localparam int CW   = $clog2(S64 + 1);
  localparam int LW   = $clog2(NDIG + 1);
  localparam logic [VALUE_WIDTH-1:0] M16 = {VALUE_WIDTH{1'b1}} >> (VALUE_WIDTH - 16);
  localparam logic [VALUE_WIDTH-1:0] M32 = {VALUE_WIDTH{1'b1}} >> (VALUE_WIDTH - W32);

  tidt_pkg::state_t   state, state_next;
  tidt_pkg::bcd_ctl_t ctl;

  logic [CW-1:0] step_cnt, step_cnt_next;
  logic [LW-1:0] left, left_next;
  logic          neg, neg_next;
  logic          sgn, sgn_next;
  logic [7:0]    one_byte, one_byte_next;

  logic          ov;
  logic [7:0]    ob;
  logic          ol;
  logic          can_emit;
  logic          emit;
  logic [7:0]    emit_byte;
  logic          emit_last;

  logic [VALUE_WIDTH-1:0] raw;
  logic [VALUE_WIDTH-1:0] msk;
  logic [VALUE_WIDTH-1:0] mag;
  logic                   sbit;
  logic                   in_sgn;
  logic [SW-1:0]          aligned;
  logic [CW-1:0]          in_steps;
  logic [3:0]             top_digit;

  tidt_bcd #(.VALUE_WIDTH(VALUE_WIDTH)) u_bcd (
    .clk       (clk),
    .ctl       (ctl),
    .load_bits (aligned),
    .top_digit (top_digit)
  );

  assign raw      = item.value[VALUE_WIDTH-1:0];
  assign in_sgn   = (item.type_code == tidt_pkg::TC_S16) || (item.type_code == tidt_pkg::TC_S32)
                    || (item.type_code == tidt_pkg::TC_S64);
  assign can_emit = !ov || text.ready;

  // magnitude and alignment of the request
  always_comb begin
    case (item.type_code) inside
      tidt_pkg::TC_U16, tidt_pkg::TC_S16: begin
        msk      = M16;
        sbit     = raw[15];
        in_steps = CW'(S16);
      end
      tidt_pkg::TC_U32, tidt_pkg::TC_S32: begin
        msk      = M32;
        sbit     = raw[W32-1];
        in_steps = CW'(S32);
      end
      default: begin
        msk      = {VALUE_WIDTH{1'b1}};
        sbit     = raw[VALUE_WIDTH-1];
        in_steps = CW'(S64);
      end
    endcase
    if (in_sgn && sbit) begin
      mag = (~(raw & msk) + VALUE_WIDTH'(1)) & msk;
    end else begin
      mag = raw & msk;
    end
    case (item.type_code) inside
      tidt_pkg::TC_U16, tidt_pkg::TC_S16: aligned = SW'(mag) << (SW - 4 * S16);
      tidt_pkg::TC_U32, tidt_pkg::TC_S32: aligned = SW'(mag) << (SW - 4 * S32);
      default:                            aligned = SW'(mag) << (SW - 4 * S64);
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= tidt_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    step_cnt <= step_cnt_next;
    left     <= left_next;
    neg      <= neg_next;
    sgn      <= sgn_next;
    one_byte <= one_byte_next;
  end

  always_comb begin
    state_next    = state;
    step_cnt_next = step_cnt;
    left_next     = left;
    neg_next      = neg;
    sgn_next      = sgn;
    one_byte_next = one_byte;
    ctl           = '0;
    item.ready    = 1'b0;
    emit          = 1'b0;
    emit_byte     = tidt_pkg::CH_TERM;
    emit_last     = 1'b0;
    unique case (state)
      tidt_pkg::S_IDLE: begin
        item.ready = 1'b1;
        if (item.valid) begin
          if (item.type_code == tidt_pkg::TC_BOOL) begin
            one_byte_next = (item.value[7:0] != 8'd0) ? tidt_pkg::CH_ONE : tidt_pkg::CH_ZERO;
            state_next    = tidt_pkg::S_ONE;
          end else if (item.type_code == tidt_pkg::TC_RAW) begin
            one_byte_next = item.value[7:0];
            state_next    = tidt_pkg::S_ONE;
          end else begin
            ctl.load      = 1'b1;
            step_cnt_next = in_steps;
            left_next     = LW'(NDIG);
            neg_next      = in_sgn && sbit;
            sgn_next      = in_sgn;
            state_next    = tidt_pkg::S_CONV;
          end
        end
      end
      tidt_pkg::S_ONE: begin
        if (can_emit) begin
          emit       = 1'b1;
          emit_byte  = one_byte;
          emit_last  = 1'b1;
          state_next = tidt_pkg::S_IDLE;
        end
      end
      tidt_pkg::S_CONV: begin
        ctl.step      = 1'b1;
        step_cnt_next = step_cnt - CW'(1);
        if (step_cnt == CW'(1)) begin
          state_next = sgn ? tidt_pkg::S_SIGN : tidt_pkg::S_SKIP;
        end
      end
      tidt_pkg::S_SIGN: begin
        if (can_emit) begin
          emit       = 1'b1;
          emit_byte  = neg ? tidt_pkg::CH_MINUS : tidt_pkg::CH_PLUS;
          state_next = tidt_pkg::S_SKIP;
        end
      end
      tidt_pkg::S_SKIP: begin
        if ((top_digit == 4'd0) && (left > LW'(1))) begin
          ctl.shift = 1'b1;
          left_next = left - LW'(1);
        end else begin
          state_next = tidt_pkg::S_DIGIT;
        end
      end
      tidt_pkg::S_DIGIT: begin
        if (can_emit) begin
          emit      = 1'b1;
          emit_byte = tidt_pkg::CH_ZERO + {4'd0, top_digit};
          ctl.shift = 1'b1;
          left_next = left - LW'(1);
          if (left == LW'(1)) begin
            state_next = tidt_pkg::S_TERM;
          end
        end
      end
      tidt_pkg::S_TERM: begin
        if (can_emit) begin
          emit       = 1'b1;
          emit_byte  = tidt_pkg::CH_TERM;
          emit_last  = 1'b1;
          state_next = tidt_pkg::S_IDLE;
        end
      end
      default: begin
        state_next = tidt_pkg::S_IDLE;
      end
    endcase
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      ov <= 1'b0;
    end else if (emit) begin
      ov <= 1'b1;
    end else if (text.ready) begin
      ov <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      ob <= emit_byte;
      ol <= emit_last;
    end
  end

  assign text.valid    = ov;
  assign text.out_byte = ob;
  assign text.last     = ol;

  a_conv_cnt: assert property (@(posedge clk) disable iff (rst)
    state == tidt_pkg::S_CONV |-> step_cnt != CW'(0))
    else $error("conversion step count ran out");

  a_digit_left: assert property (@(posedge clk) disable iff (rst)
    state == tidt_pkg::S_DIGIT |-> left != LW'(0))
    else $error("digit count ran out");

  a_mid_nonzero: assert property (@(posedge clk) disable iff (rst)
    (emit && !emit_last) |-> emit_byte != tidt_pkg::CH_TERM)
    else $error("terminator emitted inside a run");

  a_busy: assert property (@(posedge clk) disable iff (rst)
    (item.valid && item.ready) |=> state != tidt_pkg::S_IDLE)
    else $error("request accepted without leaving idle");

  a_emit_room: assert property (@(posedge clk) disable iff (rst)
    emit |-> (!ov || text.ready))
    else $error("output register overwritten");

endmodule
